>>> hw/rtl/lga_pkg.sv
// lga_pkg: shared types and constants for the life automaton grid
// used by lga_lane, lga_row and life_automaton_grid; no dependencies
package lga_pkg;

  localparam int ROW_W  = 64;
  localparam int IDX_W  = 6;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_STEP = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // 3x3 neighborhood of one cell, bit 0 left, bit 1 center, bit 2 right
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] mid;
    logic [2:0] below;
  } nbhd_t;

endpackage

>>> hw/rtl/lga_lane.sv
// lga_lane: next state of one cell under rule b3/s23
// depends on lga_pkg for the neighborhood struct
module lga_lane (
  input  lga_pkg::nbhd_t nb,
  output logic           alive
);

  logic [lga_pkg::CNT_W-1:0] n;

  always_comb begin
    n = lga_pkg::CNT_W'(nb.above[0]) + lga_pkg::CNT_W'(nb.above[1])
      + lga_pkg::CNT_W'(nb.above[2]) + lga_pkg::CNT_W'(nb.mid[0])
      + lga_pkg::CNT_W'(nb.mid[2])   + lga_pkg::CNT_W'(nb.below[0])
      + lga_pkg::CNT_W'(nb.below[1]) + lga_pkg::CNT_W'(nb.below[2]);
    alive = (n == lga_pkg::CNT_W'(3)) || (nb.mid[1] && (n == lga_pkg::CNT_W'(2)));
  end

endmodule

>>> hw/rtl/lga_row.sv
// lga_row: one lane per column computes a full next-generation row
// depends on lga_pkg and lga_lane; merges lane bits into one row word
module lga_row #(
  parameter int SIDE = 64
) (
  input  logic [lga_pkg::ROW_W-1:0] above,
  input  logic [lga_pkg::ROW_W-1:0] mid,
  input  logic [lga_pkg::ROW_W-1:0] below,
  output logic [lga_pkg::ROW_W-1:0] word
);

  logic [lga_pkg::ROW_W-1:0] lane_bits;

  for (genvar c = 0; c < lga_pkg::ROW_W; c++) begin : g_col
    if (c < SIDE) begin : g_lane
      localparam int CL = (c == 0) ? SIDE - 1 : c - 1;
      localparam int CR = (c == SIDE - 1) ? 0 : c + 1;
      lga_pkg::nbhd_t nb;
      assign nb.above = {above[CR], above[c], above[CL]};
      assign nb.mid   = {mid[CR], mid[c], mid[CL]};
      assign nb.below = {below[CR], below[c], below[CL]};
      lga_lane u_lane (
        .nb    (nb),
        .alive (lane_bits[c])
      );
    end else begin : g_pad
      assign lane_bits[c] = 1'b0;
    end
  end

  // merge: columns beyond the grid stay dead
  assign word = lane_bits;

endmodule

>>> hw/rtl/life_automaton_grid.sv
// life_automaton_grid: toroidal game of life grid held as row words
// depends on lga_pkg and lga_row; ping-pong row memory with swap
//
// Input beats (s_*) carry a mode in s_tuser: load a row, advance one
// generation, or read a row. s_tdata holds the row index and the row cells.
// Output beats (m_*) carry one row word per read, in request order.
// A load is written to memory as it is accepted. A read returns its row
// through a registered memory read and a two-entry output queue, so
// back-to-back reads run at one beat per cycle while the receiver keeps up.
// An advance sweeps the front grid one row per cycle through the single
// memory read port, SIDE + 2 reads, while SIDE column lanes compute each new
// row into the back grid; the block is busy until the last new row is
// written and then swaps front and back.
// Reset clears per-row valid bits so every cell reads dead, and selects
// grid zero as the front; no clearing pass is needed.
// When the receiver stalls the output queue fills and s_tready drops once
// two results are held or in flight; nothing is lost.
// Rows at or above SIDE are ignored for load and read back as zero.
module life_automaton_grid #(
  parameter int SIDE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [71:0]               s_tdata,  // row_index[5:0], row_cells[69:6], zero pad
  input  logic [lga_pkg::MODE_W-1:0] s_tuser, // mode[1:0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lga_pkg::ROW_W-1:0] m_tdata   // row_out[63:0]
);

  localparam int RW    = $clog2(SIDE);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int GW    = $clog2(SIDE + 2);
  localparam logic [lga_pkg::ROW_W:0] ONE_EXT = (lga_pkg::ROW_W + 1)'(1);
  localparam logic [lga_pkg::ROW_W-1:0] ROW_MASK =
    lga_pkg::ROW_W'((ONE_EXT << SIDE) - ONE_EXT);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GEN  = 2'b10
  } state_t;

  state_t st, st_next;

  logic [lga_pkg::IDX_W-1:0] in_row;
  logic [lga_pkg::ROW_W-1:0] in_cells;
  lga_pkg::mode_t            in_mode;
  logic                      in_acc, in_range;

  assign in_row   = s_tdata[lga_pkg::IDX_W-1:0];
  assign in_cells = s_tdata[lga_pkg::IDX_W +: lga_pkg::ROW_W];
  assign in_mode  = lga_pkg::mode_t'(s_tuser);
  assign in_acc   = s_tvalid && s_tready;
  assign in_range = (7'(in_row) < 7'(SIDE));

  // row memory and valid bits
  logic [lga_pkg::ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld;
  logic                      front_select;

  logic [AW-1:0]             ra, wa;
  logic                      rd_en_ok, we;
  logic [lga_pkg::ROW_W-1:0] wd;
  logic [lga_pkg::ROW_W-1:0] rd_q, rd_eff;
  logic                      rd_ok, rd_pend;

  // generation sweep
  logic [GW-1:0]             gi;
  logic                      g_issue, gen_dv, gen_wr, gen_last;
  logic [GW-1:0]             gen_di;
  logic [RW-1:0]             g_rrow, g_wrow;
  logic [lga_pkg::ROW_W-1:0] win_top, win_mid, gen_word;

  assign g_issue = (st == ST_GEN) && (gi <= GW'(SIDE + 1));
  assign gen_wr  = gen_dv && (gen_di >= GW'(2));
  assign gen_last = gen_dv && (gen_di == GW'(SIDE + 1));

  always_comb begin
    if (gi == '0) begin
      g_rrow = RW'(SIDE - 1);
    end else if (gi <= GW'(SIDE)) begin
      g_rrow = RW'(gi - GW'(1));
    end else begin
      g_rrow = '0;
    end
    g_wrow = RW'(gen_di - GW'(2));
  end

  always_comb begin
    if (g_issue) begin
      ra       = {front_select, g_rrow};
      rd_en_ok = 1'b1;
    end else begin
      ra       = {front_select, in_row[RW-1:0]};
      rd_en_ok = in_range;
    end
    if (gen_wr) begin
      we = 1'b1;
      wa = {~front_select, g_wrow};
      wd = gen_word;
    end else begin
      we = in_acc && (in_mode == lga_pkg::MODE_LOAD) && in_range;
      wa = {front_select, in_row[RW-1:0]};
      wd = in_cells & ROW_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= vld[ra] && rd_en_ok;
      if (we) begin
        vld[wa] <= 1'b1;
      end
    end
  end

  assign rd_eff = rd_ok ? rd_q : '0;

  lga_row #(
    .SIDE (SIDE)
  ) u_row (
    .above (win_top),
    .mid   (win_mid),
    .below (rd_eff),
    .word  (gen_word)
  );

  always_ff @(posedge clk) begin
    if (gen_dv) begin
      win_top <= win_mid;
      win_mid <= rd_eff;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (in_acc && (in_mode == lga_pkg::MODE_STEP)) begin
          st_next = ST_GEN;
        end
      end
      ST_GEN: begin
        if (gen_last) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      gi           <= '0;
      gen_dv       <= 1'b0;
      gen_di       <= '0;
      front_select <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      st      <= st_next;
      gen_dv  <= g_issue;
      gen_di  <= gi;
      rd_pend <= in_acc && (in_mode == lga_pkg::MODE_READ);
      if (st == ST_IDLE) begin
        gi <= '0;
      end else if (g_issue) begin
        gi <= gi + GW'(1);
      end
      if (gen_last) begin
        front_select <= ~front_select;
      end
    end
  end

  // two-entry output queue
  logic [lga_pkg::ROW_W-1:0] q_data [2];
  logic                      q_wp, q_rp;
  logic [1:0]                q_cnt;
  logic                      push, pop;
  logic [2:0]                occ;

  assign push = rd_pend;
  assign pop  = m_tvalid && m_tready;
  assign occ  = 3'(q_cnt) + 3'(rd_pend) - 3'(pop);

  assign m_tvalid = (q_cnt != 2'd0);
  assign m_tdata  = q_data[q_rp];
  assign s_tready = (st == ST_IDLE) && (occ <= 3'd1);

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[q_wp] <= rd_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp  <= 1'b0;
      q_rp  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (push) begin
        q_wp <= ~q_wp;
      end
      if (pop) begin
        q_rp <= ~q_rp;
      end
      q_cnt <= 2'(3'(q_cnt) + 3'(push) - 3'(pop));
    end
  end

  a_gen_wr_in_gen: assert property (@(posedge clk) disable iff (rst)
    gen_wr |-> (st == ST_GEN))
    else $error("generation write outside a sweep");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (q_cnt != 2'd2))
    else $error("output queue overflow");

  a_read_pending: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_mode == lga_pkg::MODE_READ)) |=> rd_pend)
    else $error("accepted read lost");

  a_swap_at_end: assert property (@(posedge clk) disable iff (rst)
    (front_select != $past(front_select)) |-> $past(gen_last))
    else $error("grid swap outside end of sweep");

endmodule

>>> tb/life_automaton_grid_tb.sv
// life_automaton_grid_tb: self-checking bench for the toroidal life grid
// directed table then random load/step/read beats against a b3/s23 grid predictor
// depends on lga_pkg and the life_automaton_grid rtl
module life_automaton_grid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE       = 64;
  localparam int N_RAND     = 500;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL       = 2 * SIDE + 20;

  typedef struct packed {
    lga_pkg::mode_t mode;
    logic [5:0]     row;
    logic [63:0]    cells;
    logic           typed;
    logic [63:0]    want;
  } vec_t;

  localparam int N_DIR = 24;
  localparam vec_t DIR_VECS [N_DIR] = '{
    '{lga_pkg::MODE_READ, 6'd0,  64'h0,                  1'b1, 64'h0},
    '{lga_pkg::MODE_READ, 6'd63, 64'h0,                  1'b1, 64'h0},
    '{lga_pkg::MODE_LOAD, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd0,  64'h0,                  1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{lga_pkg::MODE_LOAD, 6'd63, 64'h8000_0000_0000_0001, 1'b0, 64'h0},
    '{lga_pkg::MODE_NONE, 6'd0,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd0,  64'h0,                  1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{lga_pkg::MODE_READ, 6'd63, 64'h0,                  1'b1, 64'h8000_0000_0000_0001},
    '{lga_pkg::MODE_LOAD, 6'd0,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_LOAD, 6'd63, 64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_LOAD, 6'd1,  64'h8000_0000_0000_0003, 1'b0, 64'h0},
    '{lga_pkg::MODE_STEP, 6'd0,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd0,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd1,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd2,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_STEP, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd1,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_LOAD, 6'd32, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{lga_pkg::MODE_LOAD, 6'd33, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{lga_pkg::MODE_STEP, 6'd0,  64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd32, 64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd33, 64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd31, 64'h0,                  1'b0, 64'h0},
    '{lga_pkg::MODE_READ, 6'd34, 64'h0,                  1'b0, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  logic [63:0] life_rows [SIDE];
  logic [63:0] expected_rows [$];
  int          err_count = 0;
  int          rows_seen = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          held = 1'b0;

  life_automaton_grid #(.SIDE(SIDE)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one b3/s23 generation on the torus
  task automatic evolve_grid();
    logic [63:0] nxt [SIDE];
    int n;
    for (int r = 0; r < SIDE; r++) begin
      nxt[r] = '0;
      for (int c = 0; c < SIDE; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += life_rows[(r + dr + SIDE) % SIDE][(c + dc + SIDE) % SIDE];
            end
          end
        end
        if (n == 3 || (n == 2 && life_rows[r][c])) begin
          nxt[r][c] = 1'b1;
        end
      end
    end
    for (int r = 0; r < SIDE; r++) begin
      life_rows[r] = nxt[r];
    end
  endtask

  task automatic apply_beat(vec_t v);
    case (v.mode)
      lga_pkg::MODE_LOAD: begin
        if (v.row < SIDE) life_rows[v.row] = v.cells;
      end
      lga_pkg::MODE_STEP: begin
        evolve_grid();
      end
      lga_pkg::MODE_READ: begin
        if (v.typed) expected_rows.push_back(v.want);
        else expected_rows.push_back((v.row < SIDE) ? life_rows[v.row] : 64'h0);
      end
      default: begin
      end
    endcase
  endtask

  // called at a rising edge; returns at the rising edge the beat is taken
  task automatic send_beat(vec_t v);
    bit taken;
    while (!no_idle && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= v.mode;
    s_tdata  <= {2'b00, v.cells, v.row};
    do begin
      @(negedge clk);
      taken = s_tready;
      if (taken) apply_beat(v);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_pause();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_rows.size() != 0);
  endtask

  function automatic logic [63:0] pick_cells();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a;
      1: return 64'h0;
      2: return 64'hFFFF_FFFF_FFFF_FFFF;
      3: return 64'h1 << $urandom_range(63);
      default: return a & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // receiver: random stall, one long hold once 120 rows have been seen
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && !held && rows_seen >= 120) begin
        held = 1'b1;
        m_tready <= 1'b0;
        for (int i = 0; i < HOLD_LEN; i++) @(posedge clk);
      end
      m_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // output check and watchdog, sampled away from the driving edge
  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[life_automaton_grid] ERROR");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          $error("row_out beat with nothing expected: got %h", m_tdata);
          err_count++;
        end else begin
          if (m_tdata !== expected_rows[0]) begin
            $error("row_out mismatch: expected %h, got %h", expected_rows[0], m_tdata);
            err_count++;
          end
          void'(expected_rows.pop_front());
        end
      end
    end
  end

  initial begin
    vec_t v;
    int   sent;
    int   pick;
    for (int r = 0; r < SIDE; r++) life_rows[r] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_beat(DIR_VECS[i]);
    end
    drain_pause();

    sent = 0;
    while (sent < N_RAND) begin
      no_idle = (sent >= 150 && sent < 250);
      if (sent == 350) drain_pause();
      pick = $urandom_range(99);
      v.typed = 1'b0;
      v.want  = '0;
      v.row   = 6'($urandom_range(63));
      v.cells = pick_cells();
      if (pick < 5) v.mode = lga_pkg::MODE_NONE;
      else if (pick < 45) v.mode = lga_pkg::MODE_LOAD;
      else if (pick < 55) v.mode = lga_pkg::MODE_STEP;
      else v.mode = lga_pkg::MODE_READ;
      send_beat(v);
      if (v.mode != lga_pkg::MODE_NONE) sent++;
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (err_count == 0) begin
      $display("[life_automaton_grid] OK");
    end else begin
      $display("[life_automaton_grid] ERROR");
    end
    $finish;
  end

endmodule
